### rtl/ffba_pkg.sv
// first-fit block allocator: shared types, widths and codes
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  // fixed field widths
  localparam int ADDR_W    = 48;
  localparam int REQ_W     = 32;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;
  localparam int FLAG_W    = 3;

  // flag bit positions within one table entry
  localparam int FLAG_TAKEN = 0;
  localparam int FLAG_FIRST = 1;
  localparam int FLAG_LAST  = 2;

  // block count loaded at reset, capped at MAX_BLOCKS in the design
  localparam int CNT_RESET = 1024;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS  = 1'b0,
    CFG_BLOCKS_IN_USE = 1'b1
  } cfg_idx_t;

  // one request item
  typedef struct packed {
    op_t               operation;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  // one result item
  typedef struct packed {
    logic [ADDR_W-1:0] alloc_address;
    status_t           status;
    logic [CNT_W-1:0]  blocks_changed;
    logic [CNT_W-1:0]  free_left;
  } res_t;

  // configuration seen by the controller
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0]  count;
    logic              load;
    logic [CNT_W-1:0]  load_count;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/ffba_if.sv
// first-fit block allocator: request and result channel interfaces
// depends on ffba_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ffba_in_if;
  logic                       valid;
  logic                       ready;
  logic [0:0]                 operation;
  logic [ffba_pkg::REQ_W-1:0]  request_bytes;
  logic [ffba_pkg::ADDR_W-1:0] free_address;

  modport source (output valid, output operation, output request_bytes,
                  output free_address, input ready);
  modport sink (input valid, input operation, input request_bytes,
                input free_address, output ready);
endinterface

interface ffba_out_if;
  logic                       valid;
  logic                       ready;
  logic [ffba_pkg::ADDR_W-1:0] alloc_address;
  logic [1:0]                 status;
  logic [ffba_pkg::CNT_W-1:0]  blocks_changed;
  logic [ffba_pkg::CNT_W-1:0]  free_left;

  modport source (output valid, output alloc_address, output status,
                  output blocks_changed, output free_left, input ready);
  modport sink (input valid, input alloc_address, input status,
                input blocks_changed, input free_left, output ready);
endinterface

`default_nettype wire

### rtl/first_fit_block_allocator.sv
// first-fit block allocator: top level with configuration and output stage
// depends on ffba_pkg, ffba_if, ffba_ram and ffba_ctrl
//
// Usage: requests arrive on in_ch (valid/ready); an item is an allocate
// (request_bytes, rounded up to whole blocks of BLOCK_BYTES) or a free
// (free_address). Every item gives exactly one result item on out_ch, unless
// a write of blocks_in_use cuts its work off, with the allocated address, a
// status, the number of blocks moved and the free block count afterwards.
// Flow: the result of a zero-size allocate or a free below the heap base
// passes through the done state and then the output register to out_ch.
// An allocate walks the flag table one block per cycle up to the end of
// the chosen run, then writes the run one block per cycle; a free walks
// to the addressed block and, if a region starts there, clears that region
// one block per cycle. The pace is set by the single read and single write
// port of the flag memory. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
// Reset and a write of blocks_in_use (cfg index 1) start a clearing pass
// over the blocks in use during which no item is accepted. A stalled
// out_ch holds the result; the sequencer then waits before going idle.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ffba_in_if.sink                            in_ch,
  ffba_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ffba_pkg::CFG_W-1:0]     cfg_wdata
);
  import ffba_pkg::*;

  localparam int CNT_MAX = (MAX_BLOCKS < (2 ** CNT_W - 1)) ? MAX_BLOCKS : (2 ** CNT_W - 1);
  localparam int CNT_RST = (MAX_BLOCKS < CNT_RESET) ? MAX_BLOCKS : CNT_RESET;

  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_wr;
  logic [CNT_W-1:0]  cnt_clamped;
  logic              cnt_load;
  cfg_t              cfg;

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;
  res_t              out_res_r;

  // block count write, clamped into the managed range
  assign cnt_wr      = cfg_wdata[CNT_W-1:0];
  assign cnt_load    = cfg_we && (cfg_index == CFG_BLOCKS_IN_USE);
  assign cnt_clamped = (cnt_wr == '0) ? CNT_W'(1) :
                       ((cnt_wr > CNT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cnt_wr);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      cnt_r  <= CNT_W'(CNT_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS:  base_r <= cfg_wdata[ADDR_W-1:0];
        CFG_BLOCKS_IN_USE: cnt_r  <= cnt_clamped;
        default: begin
        end
      endcase
    end
  end

  assign cfg.base       = base_r;
  assign cfg.count      = cnt_r;
  assign cfg.load       = cnt_load;
  assign cfg.load_count = cnt_clamped;

  assign req.operation     = op_t'(in_ch.operation);
  assign req.request_bytes = in_ch.request_bytes;
  assign req.free_address  = in_ch.free_address;

  ffba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register between the sequencer and the result channel
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.alloc_address  = out_res_r.alloc_address;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.blocks_changed = out_res_r.blocks_changed;
  assign out_ch.free_left      = out_res_r.free_left;

endmodule

`default_nettype wire

### rtl/ffba_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ffba_ctrl.sv
// first-fit block allocator: sequencer over the block flag table
// depends on ffba_pkg and ffba_ram
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ffba_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ffba_pkg::req_t  req_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output ffba_pkg::res_t       res_o
);
  import ffba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int IW    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int LIM_W = CNT_W + $clog2(BLOCK_BYTES + 1);
  localparam int CNT_RST = (MAX_BLOCKS < CNT_RESET) ? MAX_BLOCKS : CNT_RESET;
  localparam logic [LIM_W-1:0]  BB_LIM  = LIM_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] BB_ADDR = ADDR_W'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_MARK, S_FIND, S_FCHK, S_CLR, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [IDX_W-1:0]  end_r, end_nxt;
  logic [CNT_W-1:0]  run_len_r, run_len_nxt;
  logic [LIM_W-1:0]  run_bytes_r, run_bytes_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [REQ_W-1:0]  bytes_r, bytes_nxt;
  logic [ADDR_W-1:0] addr_acc_r, addr_acc_nxt;
  logic [ADDR_W-1:0] start_addr_r, start_addr_nxt;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  res_t              res_r, res_nxt;

  logic              ram_we;
  logic [FLAG_W-1:0] ram_wdata;
  logic [FLAG_W-1:0] ram_rdata;

  logic              last_idx;
  logic [CNT_W-1:0]  run_len_inc;
  logic [LIM_W-1:0]  run_bytes_inc;
  logic [CNT_W:0]    fc_sum;
  logic [CNT_W-1:0]  fc_add;
  logic [CNT_W-1:0]  fc_sub;

  // flag table, read at the next cursor so that its data matches the current cursor
  ffba_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_BLOCKS)) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r),
    .wdata (ram_wdata),
    .raddr (cur_nxt),
    .rdata (ram_rdata)
  );

  // shared datapath terms
  assign last_idx      = (IW'(cur_r) == IW'(cfg_i.count - CNT_W'(1)));
  assign run_len_inc   = run_len_r + CNT_W'(1);
  assign run_bytes_inc = run_bytes_r + BB_LIM;
  assign fc_sum        = {1'b0, fc_r} + {1'b0, run_len_inc};
  assign fc_add        = (fc_sum > {1'b0, cfg_i.count}) ? cfg_i.count : fc_sum[CNT_W-1:0];
  assign fc_sub        = (fc_r >= run_len_r) ? (fc_r - run_len_r) : '0;

  assign in_ready_o  = (state_r == S_IDLE);
  assign res_valid_o = (state_r == S_DONE);
  assign res_o       = res_r;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    run_len_nxt    = run_len_r;
    run_bytes_nxt  = run_bytes_r;
    lim_nxt        = lim_r;
    off_nxt        = off_r;
    bytes_nxt      = bytes_r;
    addr_acc_nxt   = addr_acc_r;
    start_addr_nxt = start_addr_r;
    fc_nxt         = fc_r;
    res_nxt        = res_r;
    ram_we         = 1'b0;
    ram_wdata      = '0;

    unique case (state_r)
      // clear the managed part of the table
      S_INIT: begin
        ram_we = 1'b1;
        if (last_idx) begin
          state_nxt = S_IDLE;
          cur_nxt   = '0;
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      // take a request
      S_IDLE: begin
        cur_nxt = '0;
        if (in_valid_i) begin
          res_nxt.alloc_address  = '0;
          res_nxt.blocks_changed = '0;
          res_nxt.free_left      = fc_r;
          if (req_i.operation == OP_ALLOC) begin
            if (req_i.request_bytes == '0) begin
              res_nxt.status = ST_ZERO;
              state_nxt      = S_DONE;
            end else begin
              bytes_nxt     = req_i.request_bytes;
              addr_acc_nxt  = cfg_i.base;
              run_bytes_nxt = '0;
              run_len_nxt   = '0;
              state_nxt     = S_SCAN;
            end
          end else begin
            if (req_i.free_address < cfg_i.base) begin
              res_nxt.status = ST_IGNORED;
              state_nxt      = S_DONE;
            end else begin
              off_nxt   = req_i.free_address - cfg_i.base;
              lim_nxt   = BB_LIM;
              state_nxt = S_FIND;
            end
          end
        end
      end

      // look for the first free run that covers the request
      S_SCAN: begin
        if (ram_rdata[FLAG_TAKEN]) begin
          run_len_nxt   = '0;
          run_bytes_nxt = '0;
        end else begin
          run_len_nxt   = run_len_inc;
          run_bytes_nxt = run_bytes_inc;
          if (run_len_r == '0) begin
            start_nxt      = cur_r;
            start_addr_nxt = addr_acc_r;
          end
        end
        if (!ram_rdata[FLAG_TAKEN] &&
            (ADDR_W'(run_bytes_inc) >= ADDR_W'(bytes_r))) begin
          end_nxt   = cur_r;
          cur_nxt   = (run_len_r == '0) ? cur_r : start_r;
          state_nxt = S_MARK;
        end else if (last_idx) begin
          res_nxt.status = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          cur_nxt      = cur_r + IDX_W'(1);
          addr_acc_nxt = addr_acc_r + BB_ADDR;
        end
      end

      // write the run as taken with its first and last marks
      S_MARK: begin
        ram_we                 = 1'b1;
        ram_wdata[FLAG_TAKEN]  = 1'b1;
        ram_wdata[FLAG_FIRST]  = (cur_r == start_r);
        ram_wdata[FLAG_LAST]   = (cur_r == end_r);
        if (cur_r == end_r) begin
          fc_nxt                 = fc_sub;
          res_nxt.alloc_address  = start_addr_r;
          res_nxt.status         = ST_OK;
          res_nxt.blocks_changed = run_len_r;
          res_nxt.free_left      = fc_sub;
          state_nxt              = S_DONE;
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      // map the free address to a block index
      S_FIND: begin
        if (off_r < ADDR_W'(lim_r)) begin
          state_nxt = S_FCHK;
        end else if (last_idx) begin
          res_nxt.status = ST_IGNORED;
          state_nxt      = S_DONE;
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
          lim_nxt = lim_r + BB_LIM;
        end
      end

      // the block must start a region
      S_FCHK: begin
        if (ram_rdata[FLAG_FIRST]) begin
          run_len_nxt = '0;
          state_nxt   = S_CLR;
        end else begin
          res_nxt.status = ST_IGNORED;
          state_nxt      = S_DONE;
        end
      end

      // release blocks up to the last mark or the last managed block
      S_CLR: begin
        ram_we      = 1'b1;
        run_len_nxt = run_len_inc;
        if (ram_rdata[FLAG_LAST] || last_idx) begin
          fc_nxt                 = fc_add;
          res_nxt.status         = ST_OK;
          res_nxt.blocks_changed = run_len_inc;
          res_nxt.free_left      = fc_add;
          state_nxt              = S_DONE;
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      // hold the result until the output stage takes it
      S_DONE: begin
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new block count restarts the clearing sweep
    if (cfg_i.load) begin
      state_nxt = S_INIT;
      cur_nxt   = '0;
      fc_nxt    = cfg_i.load_count;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cur_r   <= '0;
      fc_r    <= CNT_W'(CNT_RST);
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      fc_r    <= fc_nxt;
    end
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    run_len_r    <= run_len_nxt;
    run_bytes_r  <= run_bytes_nxt;
    lim_r        <= lim_nxt;
    off_r        <= off_nxt;
    bytes_r      <= bytes_nxt;
    addr_acc_r   <= addr_acc_nxt;
    start_addr_r <= start_addr_nxt;
    res_r        <= res_nxt;
  end

  // free count never exceeds the managed block count
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= cfg_i.count)
    else $error("free count above block count");

  // an accepted item always starts work or a result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_i && in_ready_o |=> state_r != S_IDLE)
    else $error("accepted item left the sequencer idle");

  // a successful operation moves at least one block
  a_ok_moves: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_o && (res_o.status == ST_OK) |-> res_o.blocks_changed != '0)
    else $error("ok result with no blocks changed");

  // the cursor stays inside the managed blocks while scanning or clearing
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) || (state_r == S_CLR) |-> IW'(cur_r) < IW'(cfg_i.count))
    else $error("cursor past managed blocks");

endmodule

`default_nettype wire
